[rtl/sfcd_pkg.sv]
// Package: shared types, constants and the CRC-8 byte update for the frame decoder.
`timescale 1ns / 1ps

package sfcd_pkg;

  localparam logic [7:0] CRC_INIT = 8'hFF;
  localparam logic [7:0] CRC_POLY = 8'h31;

  // byte positions inside the 7-byte frame
  localparam logic [2:0] IDX_STATUS = 3'd0;
  localparam logic [2:0] IDX_HUM_HI = 3'd1;
  localparam logic [2:0] IDX_HUM_MID = 3'd2;
  localparam logic [2:0] IDX_SPLIT = 3'd3;
  localparam logic [2:0] IDX_TEMP_MID = 3'd4;
  localparam logic [2:0] IDX_TEMP_LO = 3'd5;
  localparam logic [2:0] IDX_CRC = 3'd6;

  localparam logic [13:0] HUM_SCALE = 14'd10000;
  localparam logic [14:0] TEMP_SCALE = 15'd20000;
  localparam logic [14:0] TEMP_OFFSET = 15'd5000;

  localparam int QUEUE_DEPTH = 2;
  localparam int QUEUE_AW = $clog2(QUEUE_DEPTH);

  // one completed frame, as handed from the front to the back
  typedef struct packed {
    logic [7:0]  status_byte;
    logic [19:0] humidity_raw;
    logic [19:0] temperature_raw;
    logic        frame_error;
  } frame_rec_t;

  typedef struct packed {
    logic not_empty;
    logic full;
  } q_status_t;

  typedef struct packed {
    logic               push;
    logic               pop;
  } q_ctrl_t;

  function automatic logic [7:0] crc8_byte(input logic [7:0] crc, input logic [7:0] b);
    logic [7:0] c;
    c = crc ^ b;
    for (int i = 0; i < 8; i++) begin
      if (c[7]) begin
        c = {c[6:0], 1'b0} ^ CRC_POLY;
      end else begin
        c = {c[6:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage

[rtl/sfcd_if.sv]
// Interfaces: byte input channel and decoded result channel.
`timescale 1ns / 1ps

interface sfcd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;
  logic       frame_start;

  modport source (output valid, output rx_byte, output frame_start, input ready);
  modport sink (input valid, input rx_byte, input frame_start, output ready);
endinterface

interface sfcd_out_if;
  logic               valid;
  logic               ready;
  logic [7:0]         status_byte;
  logic               busy_res;
  logic               calibrated;
  logic [19:0]        humidity_raw;
  logic [19:0]        temperature_raw;
  logic [13:0]        humidity_centi;
  logic signed [14:0] temperature_centi;
  logic               frame_error;

  modport source (output valid, output status_byte, output busy_res, output calibrated,
                  output humidity_raw, output temperature_raw, output humidity_centi,
                  output temperature_centi, output frame_error, input ready);
  modport sink (input valid, input status_byte, input busy_res, input calibrated,
                input humidity_raw, input temperature_raw, input humidity_centi,
                input temperature_centi, input frame_error, output ready);
endinterface

[rtl/sfcd_queue.sv]
// Short FIFO of completed frame records between the front and back parts.
`timescale 1ns / 1ps

module sfcd_queue (
  input  logic                 clk,
  input  logic                 rst_n,
  input  sfcd_pkg::q_ctrl_t    ctrl,
  input  sfcd_pkg::frame_rec_t wr_rec,
  output sfcd_pkg::frame_rec_t rd_rec,
  output sfcd_pkg::q_status_t  status
);

  localparam logic [sfcd_pkg::QUEUE_AW-1:0] LAST_PTR =
    sfcd_pkg::QUEUE_AW'(sfcd_pkg::QUEUE_DEPTH - 1);
  localparam logic [sfcd_pkg::QUEUE_AW:0] FULL_CNT =
    (sfcd_pkg::QUEUE_AW + 1)'(sfcd_pkg::QUEUE_DEPTH);

  sfcd_pkg::frame_rec_t             mem_r [sfcd_pkg::QUEUE_DEPTH];
  logic [sfcd_pkg::QUEUE_AW-1:0]    wr_ptr_r, wr_ptr_nxt;
  logic [sfcd_pkg::QUEUE_AW-1:0]    rd_ptr_r, rd_ptr_nxt;
  logic [sfcd_pkg::QUEUE_AW:0]      cnt_r, cnt_nxt;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (ctrl.push) begin
      wr_ptr_nxt = (wr_ptr_r == LAST_PTR) ? '0 : wr_ptr_r + 1'b1;
    end
    if (ctrl.pop) begin
      rd_ptr_nxt = (rd_ptr_r == LAST_PTR) ? '0 : rd_ptr_r + 1'b1;
    end
    unique case ({ctrl.push, ctrl.pop})
      2'b10:   cnt_nxt = cnt_r + 1'b1;
      2'b01:   cnt_nxt = cnt_r - 1'b1;
      default: cnt_nxt = cnt_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.push) begin
      mem_r[wr_ptr_r] <= wr_rec;
    end
  end

  assign rd_rec           = mem_r[rd_ptr_r];
  assign status.not_empty = (cnt_r != '0);
  assign status.full      = (cnt_r == FULL_CNT);

endmodule

[rtl/sfcd_front.sv]
// Front part: takes frame bytes, runs the CRC and assembles the raw fields.
`timescale 1ns / 1ps

module sfcd_front (
  input  logic                 clk,
  input  logic                 rst_n,
  sfcd_in_if.sink              in_ch,
  input  sfcd_pkg::q_status_t  q_stat,
  output logic                 push,
  output sfcd_pkg::frame_rec_t rec
);

  logic [2:0]  byte_idx_r, byte_idx_nxt;
  logic [7:0]  crc_r, crc_nxt;
  logic [7:0]  status_r, status_nxt;
  logic [19:0] hum_r, hum_nxt;
  logic [19:0] temp_r, temp_nxt;
  logic        accept;
  logic [2:0]  idx;
  logic [7:0]  crc_cur;
  logic [7:0]  b;

  assign in_ch.ready = !q_stat.full;
  assign accept      = in_ch.valid && in_ch.ready;
  assign b           = in_ch.rx_byte;

  // a start mark restarts the count and CRC before this byte is used
  assign idx     = in_ch.frame_start ? sfcd_pkg::IDX_STATUS : byte_idx_r;
  assign crc_cur = in_ch.frame_start ? sfcd_pkg::CRC_INIT : crc_r;

  assign push                = accept && (idx == sfcd_pkg::IDX_CRC);
  assign rec.status_byte     = status_r;
  assign rec.humidity_raw    = hum_r;
  assign rec.temperature_raw = temp_r;
  assign rec.frame_error     = (crc_cur != b);

  always_comb begin
    byte_idx_nxt = byte_idx_r;
    crc_nxt      = crc_r;
    status_nxt   = status_r;
    hum_nxt      = hum_r;
    temp_nxt     = temp_r;
    if (accept) begin
      if (idx == sfcd_pkg::IDX_CRC) begin
        byte_idx_nxt = sfcd_pkg::IDX_STATUS;
        crc_nxt      = sfcd_pkg::CRC_INIT;
      end else begin
        byte_idx_nxt = idx + 3'd1;
        crc_nxt      = sfcd_pkg::crc8_byte(crc_cur, b);
        unique case (idx)
          sfcd_pkg::IDX_STATUS:   status_nxt = b;
          sfcd_pkg::IDX_HUM_HI:   hum_nxt[19:12] = b;
          sfcd_pkg::IDX_HUM_MID:  hum_nxt[11:4] = b;
          sfcd_pkg::IDX_SPLIT: begin
            hum_nxt[3:0]    = b[7:4];
            temp_nxt[19:16] = b[3:0];
          end
          sfcd_pkg::IDX_TEMP_MID: temp_nxt[15:8] = b;
          default:                temp_nxt[7:0] = b;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      byte_idx_r <= sfcd_pkg::IDX_STATUS;
      crc_r      <= sfcd_pkg::CRC_INIT;
    end else begin
      byte_idx_r <= byte_idx_nxt;
      crc_r      <= crc_nxt;
    end
  end

  always_ff @(posedge clk) begin
    status_r <= status_nxt;
    hum_r    <= hum_nxt;
    temp_r   <= temp_nxt;
  end

endmodule

[rtl/sfcd_back.sv]
// Back part: scales raw values in a multiply stage and holds the result register.
`timescale 1ns / 1ps

module sfcd_back (
  input  logic                 clk,
  input  logic                 rst_n,
  input  sfcd_pkg::q_status_t  q_stat,
  input  sfcd_pkg::frame_rec_t q_rec,
  output logic                 pop,
  sfcd_out_if.source           out_ch
);

  logic                 s1_v_r, s1_v_nxt;
  sfcd_pkg::frame_rec_t s1_rec_r;
  logic [13:0]          s1_hum_r;
  logic [14:0]          s1_temp_r;
  logic                 s1_adv;
  logic [33:0]          hum_prod;
  logic [34:0]          temp_prod;

  logic                 out_v_r, out_v_nxt;
  sfcd_pkg::frame_rec_t out_rec_r;
  logic [13:0]          out_hum_r;
  logic [14:0]          out_temp_r;

  assign s1_adv = s1_v_r && (!out_v_r || out_ch.ready);
  assign pop    = q_stat.not_empty && (!s1_v_r || s1_adv);

  assign hum_prod  = 34'(q_rec.humidity_raw) * 34'(sfcd_pkg::HUM_SCALE);
  assign temp_prod = 35'(q_rec.temperature_raw) * 35'(sfcd_pkg::TEMP_SCALE);

  always_comb begin
    s1_v_nxt = s1_v_r;
    if (pop) begin
      s1_v_nxt = 1'b1;
    end else if (s1_adv) begin
      s1_v_nxt = 1'b0;
    end
    out_v_nxt = out_v_r;
    if (s1_adv) begin
      out_v_nxt = 1'b1;
    end else if (out_ch.ready) begin
      out_v_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r  <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      s1_v_r  <= s1_v_nxt;
      out_v_r <= out_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      s1_rec_r  <= q_rec;
      s1_hum_r  <= hum_prod[33:20];
      s1_temp_r <= temp_prod[34:20];
    end
    if (s1_adv) begin
      out_rec_r  <= s1_rec_r;
      out_hum_r  <= s1_hum_r;
      out_temp_r <= s1_temp_r - sfcd_pkg::TEMP_OFFSET;
    end
  end

  assign out_ch.valid             = out_v_r;
  assign out_ch.status_byte       = out_rec_r.status_byte;
  assign out_ch.busy_res          = out_rec_r.status_byte[7];
  assign out_ch.calibrated        = out_rec_r.status_byte[4] && out_rec_r.status_byte[3];
  assign out_ch.humidity_raw      = out_rec_r.humidity_raw;
  assign out_ch.temperature_raw   = out_rec_r.temperature_raw;
  assign out_ch.humidity_centi    = out_hum_r;
  assign out_ch.temperature_centi = $signed(out_temp_r);
  assign out_ch.frame_error       = out_rec_r.frame_error;

endmodule

[rtl/sensor_frame_crc_decoder.sv]
// Top level: sensor response frame decoder with CRC-8 check and unit scaling.
`timescale 1ns / 1ps

// Usage:
//   in_ch  : one response byte per transaction (rx_byte), frame_start marks
//            byte 0 and restarts the count and the CRC at any point.
//   out_ch : one transaction per completed 7-byte frame carrying status,
//            raw humidity/temperature, scaled values and frame_error.
//   Throughput: one byte per cycle, sustained; the front takes a byte every
//   cycle while the 2-entry frame queue is not full.
//   Path: after the transaction of byte 6, a frame passes queue ->
//   multiply stage -> output register before out_ch.valid rises.
//   The CRC (poly 0x31, init 0xFF) is unrolled, one byte per cycle when a
//   byte is taken; the scaling multipliers sit in their own registered stage.
//   Reset (rst_n low, synchronous): byte count to 0, CRC to 0xFF, queue and
//   result stages empty.
//   Stall: a result held on out_ch waits until out_ch.ready; meanwhile the
//   multiply stage and the queue absorb up to three frames, and in_ch.ready
//   drops only when the queue is full.

module sensor_frame_crc_decoder (
  input  logic        clk,
  input  logic        rst_n,
  sfcd_in_if.sink     in_ch,
  sfcd_out_if.source  out_ch
);

  sfcd_pkg::q_status_t  q_stat;
  sfcd_pkg::q_ctrl_t    q_ctrl;
  sfcd_pkg::frame_rec_t push_rec;
  sfcd_pkg::frame_rec_t pop_rec;
  logic                 push;
  logic                 pop;

  assign q_ctrl.push = push;
  assign q_ctrl.pop  = pop;

  // front: byte classification, CRC, field assembly
  sfcd_front u_front (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .q_stat (q_stat),
    .push   (push),
    .rec    (push_rec)
  );

  // decoupling queue of finished frames
  sfcd_queue u_queue (
    .clk    (clk),
    .rst_n  (rst_n),
    .ctrl   (q_ctrl),
    .wr_rec (push_rec),
    .rd_rec (pop_rec),
    .status (q_stat)
  );

  // back: scaling and output register
  sfcd_back u_back (
    .clk    (clk),
    .rst_n  (rst_n),
    .q_stat (q_stat),
    .q_rec  (pop_rec),
    .pop    (pop),
    .out_ch (out_ch)
  );

  // a frame is queued only on an accepted byte that is not a start mark
  a_push_src: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> (in_ch.valid && in_ch.ready && !in_ch.frame_start))
    else $error("frame queued without a valid final byte");

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    !(push && q_stat.full))
    else $error("queue written while full");

  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> q_stat.not_empty)
    else $error("queue read while empty");

  // a queued frame shows up at the back by the next cycle
  a_queue_seen: assert property (@(posedge clk) disable iff (!rst_n)
    push |=> q_stat.not_empty)
    else $error("queued frame lost");

endmodule

[test/tb_sensor_frame_crc_decoder.sv]
// Testbench: sensor frame decoder, directed table then random frames, scoreboard-checked.
`timescale 1ns / 1ps

module tb_sensor_frame_crc_decoder;

  // decoded frame as seen on the result channel; temperature kept as raw
  // two's complement bits so that compares are plain vector compares
  typedef struct packed {
    logic [7:0]  status_byte;
    logic        busy_res;
    logic        calibrated;
    logic [19:0] humidity_raw;
    logic [19:0] temperature_raw;
    logic [13:0] humidity_centi;
    logic [14:0] temperature_centi;
    logic        frame_error;
  } frame_result_t;

  // how a directed row is checked: by the predictor, or against a result
  // typed in below because it can be read straight off the frame bytes
  typedef enum logic [1:0] {
    CHK_PREDICT,
    CHK_ALL_ZERO,
    CHK_ALL_ONES,
    CHK_ZERO_BAD_CRC
  } row_check_t;

  typedef struct packed {
    logic [7:0] data;
    logic       start;
    row_check_t chk;
  } stim_row_t;

  // Directed frames:
  //   all-zero frame with start mark, CRC over six zero bytes is 0x6A
  //   all-ones frame with no start mark (count back at 0 after a frame),
  //     CRC over six 0xFF bytes is 0x22; raw values at full scale
  //   a partial frame dropped by a start mark mid-frame
  //   all-zero frame whose CRC byte is inverted -> frame_error
  localparam stim_row_t DIRECTED_ROWS [0:23] = '{
    '{8'h00, 1'b1, CHK_PREDICT}, '{8'h00, 1'b0, CHK_PREDICT},
    '{8'h00, 1'b0, CHK_PREDICT}, '{8'h00, 1'b0, CHK_PREDICT},
    '{8'h00, 1'b0, CHK_PREDICT}, '{8'h00, 1'b0, CHK_PREDICT},
    '{8'h6A, 1'b0, CHK_ALL_ZERO},
    '{8'hFF, 1'b0, CHK_PREDICT}, '{8'hFF, 1'b0, CHK_PREDICT},
    '{8'hFF, 1'b0, CHK_PREDICT}, '{8'hFF, 1'b0, CHK_PREDICT},
    '{8'hFF, 1'b0, CHK_PREDICT}, '{8'hFF, 1'b0, CHK_PREDICT},
    '{8'h22, 1'b0, CHK_ALL_ONES},
    '{8'h98, 1'b1, CHK_PREDICT}, '{8'h12, 1'b0, CHK_PREDICT},
    '{8'h34, 1'b0, CHK_PREDICT},
    '{8'h00, 1'b1, CHK_PREDICT}, '{8'h00, 1'b0, CHK_PREDICT},
    '{8'h00, 1'b0, CHK_PREDICT}, '{8'h00, 1'b0, CHK_PREDICT},
    '{8'h00, 1'b0, CHK_PREDICT}, '{8'h00, 1'b0, CHK_PREDICT},
    '{8'h95, 1'b0, CHK_ZERO_BAD_CRC}
  };

  localparam int PHASE_ITEMS = 125;
  localparam int HOLD_OFF_CYCLES = 300;
  localparam int DRAIN_CYCLES = 8;

  logic clk;
  logic rst_n;

  sfcd_in_if  in_ch ();
  sfcd_out_if out_ch ();

  sensor_frame_crc_decoder DUT (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  // predictor state, mirrors the decoder's frame position and accumulators
  logic [2:0]  frame_pos;
  logic [7:0]  crc_acc;
  logic [7:0]  status_hold;
  logic [19:0] hum_acc;
  logic [19:0] temp_acc;

  frame_result_t pending_frames[$];        // decoded frames still owed by the DUT
  frame_result_t typed_by_item[int];       // hand-typed results, keyed by byte number

  int sent_items = 0;   // byte transactions seen by the sender
  int taken_items = 0;  // byte transactions seen by the monitor
  int err_cnt = 0;
  int idle_pct = 0;     // sender idle chance per cycle, percent
  int stall_pct = 0;    // receiver stall chance per cycle, percent
  int hold_cycles = 0;  // long receiver hold-off, counted down by the receiver
  bit need_mark = 1'b1; // generator lost frame alignment, next frame gets a start mark

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // watchdog
  initial begin
    #3_000_000;
    $display("tb_sensor_frame_crc_decoder: done, errors");
    $finish;
  end

  function automatic logic [7:0] crc8_step(input logic [7:0] crc, input logic [7:0] b);
    logic [7:0] c;
    c = crc ^ b;
    repeat (8) begin
      c = c[7] ? ({c[6:0], 1'b0} ^ sfcd_pkg::CRC_POLY) : {c[6:0], 1'b0};
    end
    return c;
  endfunction

  // Advance the frame state by one byte; returns 1 when the byte closes a
  // frame, with the decoded result in r.
  function automatic bit decode_frame_byte(input logic [7:0] b, input logic start,
                                           output frame_result_t r);
    logic [63:0] prod;
    r = '0;
    if (start) begin
      frame_pos = sfcd_pkg::IDX_STATUS;
      crc_acc = sfcd_pkg::CRC_INIT;
    end
    if (frame_pos >= sfcd_pkg::IDX_CRC) begin
      r.status_byte = status_hold;
      r.busy_res = status_hold[7];
      r.calibrated = status_hold[4] & status_hold[3];
      r.humidity_raw = hum_acc;
      r.temperature_raw = temp_acc;
      prod = 64'(hum_acc) * 64'(sfcd_pkg::HUM_SCALE);
      r.humidity_centi = prod[33:20];
      prod = 64'(temp_acc) * 64'(sfcd_pkg::TEMP_SCALE);
      r.temperature_centi = prod[34:20] - sfcd_pkg::TEMP_OFFSET;
      r.frame_error = (crc_acc != b);
      frame_pos = sfcd_pkg::IDX_STATUS;
      crc_acc = sfcd_pkg::CRC_INIT;
      return 1'b1;
    end
    crc_acc = crc8_step(crc_acc, b);
    unique case (frame_pos)
      sfcd_pkg::IDX_STATUS:   status_hold = b;
      sfcd_pkg::IDX_HUM_HI:   hum_acc = {b, 12'h000};
      sfcd_pkg::IDX_HUM_MID:  hum_acc[11:4] = b;
      sfcd_pkg::IDX_SPLIT: begin
        hum_acc[3:0] = b[7:4];
        temp_acc = {b[3:0], 16'h0000};
      end
      sfcd_pkg::IDX_TEMP_MID: temp_acc[15:8] = b;
      default:                temp_acc[7:0] = b;
    endcase
    frame_pos = frame_pos + 3'd1;
    return 1'b0;
  endfunction

  function automatic frame_result_t typed_result(input row_check_t chk);
    frame_result_t r;
    r = '0;
    r.temperature_centi = -15'sd5000;
    unique case (chk)
      CHK_ALL_ONES: begin
        r.status_byte = 8'hFF;
        r.busy_res = 1'b1;
        r.calibrated = 1'b1;
        r.humidity_raw = 20'hFFFFF;
        r.temperature_raw = 20'hFFFFF;
        r.humidity_centi = 14'd9999;
        r.temperature_centi = 15'sd14999;
      end
      CHK_ZERO_BAD_CRC: r.frame_error = 1'b1;
      default: ;
    endcase
    return r;
  endfunction

  task automatic report_mismatch(input string what, input longint got, input longint want);
    err_cnt++;
    if (err_cnt <= 40)
      $display("%0t ns: %s mismatch, got %0d, want %0d", $time, what, got, want);
  endtask

  task automatic check_frame(input frame_result_t got, input frame_result_t want);
    if (got.status_byte !== want.status_byte)
      report_mismatch("status_byte", got.status_byte, want.status_byte);
    if (got.busy_res !== want.busy_res)
      report_mismatch("busy_res", got.busy_res, want.busy_res);
    if (got.calibrated !== want.calibrated)
      report_mismatch("calibrated", got.calibrated, want.calibrated);
    if (got.humidity_raw !== want.humidity_raw)
      report_mismatch("humidity_raw", got.humidity_raw, want.humidity_raw);
    if (got.temperature_raw !== want.temperature_raw)
      report_mismatch("temperature_raw", got.temperature_raw, want.temperature_raw);
    if (got.humidity_centi !== want.humidity_centi)
      report_mismatch("humidity_centi", got.humidity_centi, want.humidity_centi);
    if (got.temperature_centi !== want.temperature_centi)
      report_mismatch("temperature_centi", $signed(got.temperature_centi),
                      $signed(want.temperature_centi));
    if (got.frame_error !== want.frame_error)
      report_mismatch("frame_error", got.frame_error, want.frame_error);
  endtask

  // Monitor: both channels sampled at the rising edge, before the NBA
  // updates of that edge land, so sender and receiver order never matters.
  always @(posedge clk) begin
    frame_result_t want;
    frame_result_t got;
    if (rst_n) begin
      if (in_ch.valid && in_ch.ready) begin
        if (decode_frame_byte(in_ch.rx_byte, in_ch.frame_start, want)) begin
          if (typed_by_item.exists(taken_items)) begin
            want = typed_by_item[taken_items];
            typed_by_item.delete(taken_items);
          end
          pending_frames.push_back(want);
        end
        taken_items++;
      end
      if (out_ch.valid && out_ch.ready) begin
        got.status_byte = out_ch.status_byte;
        got.busy_res = out_ch.busy_res;
        got.calibrated = out_ch.calibrated;
        got.humidity_raw = out_ch.humidity_raw;
        got.temperature_raw = out_ch.temperature_raw;
        got.humidity_centi = out_ch.humidity_centi;
        got.temperature_centi = out_ch.temperature_centi;
        got.frame_error = out_ch.frame_error;
        if (pending_frames.size() == 0)
          report_mismatch("unexpected frame, status_byte", got.status_byte, -1);
        else
          check_frame(got, pending_frames.pop_front());
      end
    end
  end

  // Receiver: random stalls, or a long hold-off when hold_cycles is loaded.
  initial begin
    out_ch.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_cycles > 0) begin
        out_ch.ready <= 1'b0;
        hold_cycles--;
      end else begin
        out_ch.ready <= ($urandom_range(99) >= stall_pct);
      end
    end
  end

  // One byte transaction; returns at the edge where it was taken.
  task automatic send_byte(input logic [7:0] b, input logic start);
    while ($urandom_range(99) < idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.rx_byte <= b;
    in_ch.frame_start <= start;
    do @(posedge clk); while (in_ch.ready !== 1'b1);
    sent_items++;
  endtask

  // Byte values lean on the extremes so raw fields hit 0 and full scale.
  function automatic logic [7:0] pick_byte();
    unique case ($urandom_range(7))
      0:       return 8'h00;
      1:       return 8'hFF;
      default: return 8'($urandom);
    endcase
  endfunction

  // Well-formed 7-byte frame with random content; CRC byte right or wrong.
  task automatic send_frame(input logic mark, input bit crc_ok);
    logic [7:0] b;
    logic [7:0] crc;
    crc = sfcd_pkg::CRC_INIT;
    for (int i = 0; i < 6; i++) begin
      b = pick_byte();
      if (i == 0 && $urandom_range(3) == 0)
        b[4:3] = 2'b11;   // calibrated status shows up often enough
      crc = crc8_step(crc, b);
      send_byte(b, (i == 0) ? mark : 1'b0);
    end
    send_byte(crc_ok ? crc : crc ^ 8'($urandom_range(255, 1)), 1'b0);
    need_mark = 1'b0;
  endtask

  // Mostly clean frames; the rest truncated frames and stray bytes, after
  // which the next frame carries a start mark to realign.
  task automatic run_phase(input int sender_idle, input int receiver_stall, input int n);
    int stop_at;
    int roll;
    idle_pct = sender_idle;
    stall_pct = receiver_stall;
    stop_at = sent_items + n;
    while (sent_items < stop_at) begin
      roll = $urandom_range(99);
      if (roll < 75) begin
        send_frame(need_mark ? 1'b1 : 1'($urandom_range(1)), $urandom_range(9) < 8);
      end else if (roll < 87) begin
        repeat ($urandom_range(6, 1)) send_byte(pick_byte(), 1'($urandom_range(1)));
        need_mark = 1'b1;
      end else begin
        send_byte(8'($urandom), $urandom_range(3) == 0);
        need_mark = 1'b1;
      end
    end
  endtask

  // Sender pauses until every owed frame has come back.
  task automatic drain();
    in_ch.valid <= 1'b0;
    while (pending_frames.size() != 0 || taken_items != sent_items) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  initial begin
    rst_n = 1'b0;
    in_ch.valid = 1'b0;
    in_ch.rx_byte = 8'h00;
    in_ch.frame_start = 1'b0;
    frame_pos = sfcd_pkg::IDX_STATUS;
    crc_acc = sfcd_pkg::CRC_INIT;
    status_hold = 8'h00;
    hum_acc = 20'h00000;
    temp_acc = 20'h00000;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // directed table, no idling
    foreach (DIRECTED_ROWS[i]) begin
      if (DIRECTED_ROWS[i].chk != CHK_PREDICT)
        typed_by_item[sent_items] = typed_result(DIRECTED_ROWS[i].chk);
      send_byte(DIRECTED_ROWS[i].data, DIRECTED_ROWS[i].start);
    end
    drain();

    run_phase(0, 0, PHASE_ITEMS);
    drain();
    run_phase(63, 0, PHASE_ITEMS);
    drain();
    run_phase(0, 63, PHASE_ITEMS);
    drain();
    run_phase(19, 19, PHASE_ITEMS);
    drain();

    // Back-pressure: receiver holds off while bytes keep coming, so the
    // output, multiply stage and frame queue fill and in_ch.ready drops.
    idle_pct = 0;
    stall_pct = 0;
    hold_cycles = HOLD_OFF_CYCLES;
    repeat (6) send_frame(1'b1, 1'b1);
    drain();

    if (err_cnt == 0)
      $display("tb_sensor_frame_crc_decoder: done, clean");
    else
      $display("tb_sensor_frame_crc_decoder: done, errors");
    $finish;
  end

endmodule
